// ===== rtl/core/xyzlab_pkg.sv =====
// Package for the XYZ to CIELAB converter: widths, fixed-point constants,
// register indexes and the per-channel record carried down the cube-root chain.
// No dependencies.
package xyzlab_pkg;

   // default code width of the tristimulus inputs
   localparam int SAMPLE_BITS_DEF = 16;

   // configuration register indexes
   localparam logic [2:0] REG_INV_WHITE_X = 3'd0;
   localparam logic [2:0] REG_INV_WHITE_Y = 3'd1;
   localparam logic [2:0] REG_INV_WHITE_Z = 3'd2;
   localparam logic [2:0] REG_OUT_SCALE   = 3'd3;
   localparam logic [2:0] REG_OFFSET_MODE = 3'd4;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int INV_W      = 32;
   localparam int SCALE_W    = 24;

   // register reset values
   localparam logic [INV_W-1:0]   INV_WHITE_X_RST = 32'd17016777;
   localparam logic [INV_W-1:0]   INV_WHITE_Y_RST = 32'd16777216;
   localparam logic [INV_W-1:0]   INV_WHITE_Z_RST = 32'd15359587;
   localparam logic [SCALE_W-1:0] OUT_SCALE_RST   = 24'd256;

   // ratio t in Q2.24, saturating
   localparam int              T_W         = 26;
   localparam logic [T_W-1:0]  T_MAX       = '1;
   localparam logic [T_W-1:0]  T_THRESHOLD = 26'd148578;

   // linear segment: floor((9033 t + 160 * 2^24) / 296960)
   // 296960 = 2048 * 145; the /145 is a reciprocal multiply (exact for 21-bit values)
   localparam int             LIN_T_W    = 18;
   localparam int             LIN_N_W    = 33;
   localparam int             LIN_Q_W    = 21;
   localparam int             LIN_W      = 14;
   localparam logic [LIN_N_W-1:0] LIN_MUL  = 33'd9033;
   localparam logic [LIN_N_W-1:0] LIN_BIAS = 33'd2684354560;
   localparam logic [21:0]    LIN_RECIP  = 22'd3702559;
   localparam int             LIN_SHIFT  = 29;

   // cube root chain
   localparam int ROOT_CELLS = 17;
   localparam int ROOT_W     = 17;
   localparam int SQ_W       = 34;
   localparam int REM_W      = 50;
   localparam int CMP_W      = 53;

   // back end: L = floor((116 fy - 2^20) / 100) via w = 116 fy + 24, /4 then /25
   localparam int              V_W      = 21;
   localparam int              W_W      = 24;
   localparam logic [W_W-1:0]  L_MUL    = 24'd116;
   localparam logic [W_W-1:0]  L_ADD    = 24'd24;
   localparam logic [22:0]     L_RECIP  = 23'd5368710;
   localparam int              L_SHIFT  = 27;
   localparam int              L_BIAS   = 10486;
   localparam int              Q16_ONE  = 65536;
   localparam int              P_W      = V_W + SCALE_W + 1;
   localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic              sel;   // t above threshold: use the cube root
      logic [LIN_W-1:0]  lin;   // linear-segment result
      logic [REM_W-1:0]  rem;   // cube root remainder
      logic [ROOT_W-1:0] root;  // partial root
      logic [SQ_W-1:0]   sq;    // root squared
   } chan_type;

   typedef chan_type [2:0] pix_type;

endpackage

// ===== rtl/core/xyzlab_front.sv =====
// Front end: ratio against white point, saturation, and the linear segment
// of the companding curve, three registered stages. Depends on xyzlab_pkg.
module xyzlab_front #(
   parameter int SAMPLE_BITS = xyzlab_pkg::SAMPLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [SAMPLE_BITS-1:0] x_value,
   input  logic [SAMPLE_BITS-1:0] y_value,
   input  logic [SAMPLE_BITS-1:0] z_value,
   input  logic [31:0]            inv_x,
   input  logic [31:0]            inv_y,
   input  logic [31:0]            inv_z,
   output logic                   out_valid,
   input  logic                   out_ready,
   output xyzlab_pkg::pix_type    out_pix
);
   import xyzlab_pkg::*;

   localparam int PROD_W = SAMPLE_BITS + INV_W;

   logic [2:0]                 valid_ff;
   logic [2:0]                 rdy;
   logic [SAMPLE_BITS-1:0]     code [3];
   logic [INV_W-1:0]           inv [3];
   logic [PROD_W-1:0]          prod [3];
   logic [INV_W-1:0]           ratio [3];
   logic [T_W-1:0]             t0_in [3];
   logic [T_W-1:0]             t0_ff [3];
   logic [T_W-1:0]             t1_ff [3];
   logic [LIN_N_W-1:0]         num [3];
   logic [LIN_Q_W-1:0]         n1_in [3];
   logic [LIN_Q_W-1:0]         n1_ff [3];
   logic [LIN_Q_W+21:0]        qp [3];
   pix_type                    pix_in;
   pix_type                    pix_ff;

   // stage handshake: a stage loads when empty or when it drains
   assign rdy[2]    = !valid_ff[2] || out_ready;
   assign rdy[1]    = !valid_ff[1] || rdy[2];
   assign rdy[0]    = !valid_ff[0] || rdy[1];
   assign in_ready  = rdy[0];
   assign out_valid = valid_ff[2];
   assign out_pix   = pix_ff;

   assign code[0] = x_value;
   assign code[1] = y_value;
   assign code[2] = z_value;
   assign inv[0]  = inv_x;
   assign inv[1]  = inv_y;
   assign inv[2]  = inv_z;

   // per-channel arithmetic
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         prod[c]  = PROD_W'(code[c]) * PROD_W'(inv[c]);
         ratio[c] = prod[c][PROD_W-1:SAMPLE_BITS];
         t0_in[c] = (ratio[c] > INV_W'(T_MAX)) ? T_MAX : ratio[c][T_W-1:0];

         num[c]   = LIN_N_W'(t0_ff[c][LIN_T_W-1:0]) * LIN_MUL + LIN_BIAS;
         n1_in[c] = num[c][31:11];

         qp[c]    = (LIN_Q_W+22)'(n1_ff[c]) * (LIN_Q_W+22)'(LIN_RECIP);
         pix_in[c].sel  = t1_ff[c] > T_THRESHOLD;
         pix_in[c].lin  = qp[c][LIN_SHIFT+LIN_W-1:LIN_SHIFT];
         pix_in[c].rem  = {t1_ff[c], 24'd0};
         pix_in[c].root = '0;
         pix_in[c].sq   = '0;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (rdy[0]) valid_ff[0] <= in_valid;
         if (rdy[1]) valid_ff[1] <= valid_ff[0];
         if (rdy[2]) valid_ff[2] <= valid_ff[1];
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (rdy[0]) t0_ff <= t0_in;
      if (rdy[1]) begin
         t1_ff <= t0_ff;
         n1_ff <= n1_in;
      end
      if (rdy[2]) pix_ff <= pix_in;
   end

endmodule

// ===== rtl/core/xyzlab_root_cell.sv =====
// One cell of the cube root chain: settles one root bit for all three channels
// and hands the pixel to the next cell. Depends on xyzlab_pkg.
module xyzlab_root_cell #(
   parameter int BIT = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  xyzlab_pkg::pix_type in_pix,
   output logic                out_valid,
   input  logic                out_ready,
   output xyzlab_pkg::pix_type out_pix
);
   import xyzlab_pkg::*;

   logic              valid_ff;
   pix_type           pix_in;
   pix_type           pix_ff;
   logic [ROOT_W-1:0] y2 [3];
   logic [SQ_W-1:0]   sq2 [3];
   logic [CMP_W-1:0]  tri3 [3];
   logic [CMP_W-1:0]  step [3];

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_pix   = pix_ff;

   // restoring digit step: try bit, subtract 3y(y+1)+1 scaled by 2^(3*BIT)
   always_comb begin
      pix_in = in_pix;
      for (int c = 0; c < 3; c++) begin
         y2[c]   = {in_pix[c].root[ROOT_W-2:0], 1'b0};
         sq2[c]  = {in_pix[c].sq[SQ_W-3:0], 2'b00};
         tri3[c] = (CMP_W'(sq2[c]) + CMP_W'(y2[c])) * CMP_W'(3) + CMP_W'(1);
         step[c] = tri3[c] << (3 * BIT);
         if (CMP_W'(in_pix[c].rem) >= step[c]) begin
            pix_in[c].rem  = in_pix[c].rem - step[c][REM_W-1:0];
            pix_in[c].root = y2[c] | ROOT_W'(1);
            pix_in[c].sq   = sq2[c] + (SQ_W'(y2[c]) << 1) + SQ_W'(1);
         end else begin
            pix_in[c].root = y2[c];
            pix_in[c].sq   = sq2[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) pix_ff <= pix_in;
   end

endmodule

// ===== rtl/core/xyzlab_back.sv =====
// Back end: picks f per channel, forms L, a and b, applies offset mode and
// the output scale with saturation; last stage is the output register.
// Depends on xyzlab_pkg.
module xyzlab_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  xyzlab_pkg::pix_type                in_pix,
   input  logic                               offset_mode,
   input  logic [xyzlab_pkg::SCALE_W-1:0]     out_scale,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic signed [31:0]                 lightness,
   output logic signed [31:0]                 green_red,
   output logic signed [31:0]                 blue_yellow
);
   import xyzlab_pkg::*;

   logic [2:0]              valid_ff;
   logic [2:0]              rdy;
   logic [ROOT_W-1:0]       f [3];
   logic signed [V_W-1:0]   fs [3];
   logic [W_W-1:0]          w;
   logic signed [V_W-1:0]   a_raw;
   logic signed [V_W-1:0]   b_raw;
   logic signed [V_W-1:0]   a0_in;
   logic signed [V_W-1:0]   b0_in;
   logic [W_W-3:0]          w0_ff;
   logic signed [V_W-1:0]   a0_ff;
   logic signed [V_W-1:0]   b0_ff;
   logic [44:0]             lp;
   logic signed [V_W-1:0]   l1_in;
   logic signed [V_W-1:0]   v1_ff [3];
   logic signed [P_W-1:0]   prod [3];
   logic signed [P_W-1:0]   shifted [3];
   logic signed [31:0]      res_in [3];
   logic signed [31:0]      res_ff [3];

   assign rdy[2]      = !valid_ff[2] || out_ready;
   assign rdy[1]      = !valid_ff[1] || rdy[2];
   assign rdy[0]      = !valid_ff[0] || rdy[1];
   assign in_ready    = rdy[0];
   assign out_valid   = valid_ff[2];
   assign lightness   = res_ff[0];
   assign green_red   = res_ff[1];
   assign blue_yellow = res_ff[2];

   // stage 0: f select, L numerator, a and b with optional offset
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         f[c]  = in_pix[c].sel ? in_pix[c].root : ROOT_W'(in_pix[c].lin);
         fs[c] = signed'(V_W'(f[c]));
      end
      w     = W_W'(f[1]) * L_MUL + L_ADD;
      a_raw = (fs[0] - fs[1]) * V_W'(5);
      b_raw = (fs[1] - fs[2]) <<< 1;
      a0_in = offset_mode ? ((a_raw + V_W'(Q16_ONE)) >>> 1) : a_raw;
      b0_in = offset_mode ? ((b_raw + V_W'(Q16_ONE)) >>> 1) : b_raw;
   end

   // stage 1: divide by 25 through a reciprocal, remove the bias
   always_comb begin
      lp    = 45'(w0_ff) * 45'(L_RECIP);
      l1_in = signed'(V_W'(lp[L_SHIFT+17:L_SHIFT])) - V_W'(L_BIAS);
   end

   // stage 2: output scale, floor by 256, saturate
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         prod[c]    = P_W'(v1_ff[c]) * signed'(P_W'(out_scale));
         shifted[c] = prod[c] >>> 8;
         if (shifted[c] > P_W'(SAT_MAX)) begin
            res_in[c] = SAT_MAX;
         end else if (shifted[c] < P_W'(SAT_MIN)) begin
            res_in[c] = SAT_MIN;
         end else begin
            res_in[c] = shifted[c][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (rdy[0]) valid_ff[0] <= in_valid;
         if (rdy[1]) valid_ff[1] <= valid_ff[0];
         if (rdy[2]) valid_ff[2] <= valid_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         w0_ff <= w[W_W-1:2];
         a0_ff <= a0_in;
         b0_ff <= b0_in;
      end
      if (rdy[1]) begin
         v1_ff[0] <= l1_in;
         v1_ff[1] <= a0_ff;
         v1_ff[2] <= b0_ff;
      end
      if (rdy[2]) res_ff <= res_in;
   end

endmodule

// ===== rtl/core/xyz_to_cielab_converter.sv =====
// Top level of the XYZ to CIELAB converter: configuration registers, front
// end, cube root cell chain and back end. Depends on xyzlab_pkg and submodules.
//
// Usage:
//   req_* carries one XYZ pixel per beat (valid/ready); rsp_* returns the
//   L, a, b beat for it, in order (valid/ready). csr_* is a write-only port
//   (enable, index, data) taking effect at once; write it only while idle.
//   Throughput: one pixel per clock when rsp_ready stays high.
//   Pipeline: 23 register stages between the request beat and rsp_valid:
//   3 front-end stages (ratio multiply, linear numerator, reciprocal
//   divide), 17 chain cells that each settle one bit of the 17-bit cube
//   root, and 3 back-end stages (L/a/b, divide by 100, output scaling into
//   the output register).
//   Every stage holds its beat while the next is full, so a stalled receiver
//   fills the pipeline before req_ready drops; empty stages keep accepting.
//   Reset (synchronous) empties all stages and loads the register defaults:
//   default white reciprocals, unit output scale, offset mode off.
module xyz_to_cielab_converter #(
   parameter int SAMPLE_BITS = xyzlab_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [SAMPLE_BITS-1:0]              req_x_value,
   input  logic [SAMPLE_BITS-1:0]              req_y_value,
   input  logic [SAMPLE_BITS-1:0]              req_z_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [31:0]                  rsp_lightness,
   output logic signed [31:0]                  rsp_green_red,
   output logic signed [31:0]                  rsp_blue_yellow,
   input  logic                                csr_write_en,
   input  logic [xyzlab_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [xyzlab_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import xyzlab_pkg::*;

   logic [INV_W-1:0]   inv_white_x_ff;
   logic [INV_W-1:0]   inv_white_y_ff;
   logic [INV_W-1:0]   inv_white_z_ff;
   logic [SCALE_W-1:0] out_scale_ff;
   logic               offset_mode_ff;

   pix_type            chain_pix   [ROOT_CELLS+1];
   logic               chain_valid [ROOT_CELLS+1];
   logic               chain_ready [ROOT_CELLS+1];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_white_x_ff <= INV_WHITE_X_RST;
         inv_white_y_ff <= INV_WHITE_Y_RST;
         inv_white_z_ff <= INV_WHITE_Z_RST;
         out_scale_ff   <= OUT_SCALE_RST;
         offset_mode_ff <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_INV_WHITE_X: inv_white_x_ff <= csr_write_data;
            REG_INV_WHITE_Y: inv_white_y_ff <= csr_write_data;
            REG_INV_WHITE_Z: inv_white_z_ff <= csr_write_data;
            REG_OUT_SCALE:   out_scale_ff   <= csr_write_data[SCALE_W-1:0];
            REG_OFFSET_MODE: offset_mode_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // ratio and linear segment
   xyzlab_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .x_value   (req_x_value),
      .y_value   (req_y_value),
      .z_value   (req_z_value),
      .inv_x     (inv_white_x_ff),
      .inv_y     (inv_white_y_ff),
      .inv_z     (inv_white_z_ff),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_pix   (chain_pix[0])
   );

   // cube root chain, most significant root bit first
   for (genvar g = 0; g < ROOT_CELLS; g++) begin : g_cell
      xyzlab_root_cell #(.BIT(ROOT_CELLS - 1 - g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[g]),
         .in_ready  (chain_ready[g]),
         .in_pix    (chain_pix[g]),
         .out_valid (chain_valid[g+1]),
         .out_ready (chain_ready[g+1]),
         .out_pix   (chain_pix[g+1])
      );
   end

   // L, a, b and output scaling
   xyzlab_back u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (chain_valid[ROOT_CELLS]),
      .in_ready    (chain_ready[ROOT_CELLS]),
      .in_pix      (chain_pix[ROOT_CELLS]),
      .offset_mode (offset_mode_ff),
      .out_scale   (out_scale_ff),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .lightness   (rsp_lightness),
      .green_red   (rsp_green_red),
      .blue_yellow (rsp_blue_yellow)
   );

endmodule

// ===== rtl/core/xyzlab_checker.sv =====
// Port-level checks for the XYZ to CIELAB converter, bound to its top level.
// Depends only on the top level's port names.
module xyzlab_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_lightness,
   input logic [31:0] rsp_green_red,
   input logic [31:0] rsp_blue_yellow
);

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // an empty output means every stage can take a beat
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   // a draining receiver never stalls the input
   a_drain_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request stalled while response drains");

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_lightness)
         && $stable(rsp_green_red) && $stable(rsp_blue_yellow))
      else $error("stalled response beat changed");

endmodule

bind xyz_to_cielab_converter xyzlab_checker u_xyzlab_checker (.*);

// ===== verif/xyz_to_cielab_checker.sv =====
// Checker for the XYZ to CIELAB converter: watches the pixel and result
// channels, predicts L/a/b per accepted pixel and compares in order.
// Depends on xyzlab_pkg.
module xyz_to_cielab_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [15:0]                         req_x_value,
   input  logic [15:0]                         req_y_value,
   input  logic [15:0]                         req_z_value,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [31:0]                  rsp_lightness,
   input  logic signed [31:0]                  rsp_green_red,
   input  logic signed [31:0]                  rsp_blue_yellow,
   input  logic                                csr_write_en,
   input  logic [xyzlab_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [xyzlab_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output int                                  error_count,
   output int                                  pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import xyzlab_pkg::*;

   typedef struct packed {
      logic signed [31:0] lightness;
      logic signed [31:0] green_red;
      logic signed [31:0] blue_yellow;
   } lab_type;

   // shadow copy of the registers
   logic [INV_W-1:0]   inv_x, inv_y, inv_z;
   logic [SCALE_W-1:0] scale;
   logic               offset_on;
   lab_type            lab_queue[$];

   // floor division by a positive divisor
   function automatic longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q = q - 1;
      return q;
   endfunction

   // f(t) for one channel, in Q16
   function automatic longint companded(logic [15:0] code, logic [31:0] inv);
      longint unsigned t, n, r, c;
      t = (longint'(code) * longint'(inv)) >> 16;
      if (t > longint'(T_MAX)) t = longint'(T_MAX);
      if (t > longint'(T_THRESHOLD)) begin
         n = t << 24;
         r = 0;
         for (int b = 16; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c * c <= n) r = c;
         end
         return longint'(r);
      end
      return longint'((9033 * t + 160 * (64'd1 << 24)) / 296960);
   endfunction

   function automatic logic signed [31:0] scaled(longint v);
      longint r;
      r = floor_div(v * longint'(scale), 256);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[31:0];
   endfunction

   function automatic lab_type predict_lab(logic [15:0] xv, logic [15:0] yv,
                                           logic [15:0] zv);
      longint fx, fy, fz, l, a, b;
      lab_type res;
      fx = companded(xv, inv_x);
      fy = companded(yv, inv_y);
      fz = companded(zv, inv_z);
      l = floor_div(116 * fy - 16 * Q16_ONE, 100);
      a = 5 * (fx - fy);
      b = 2 * (fy - fz);
      if (offset_on) begin
         a = floor_div(a + Q16_ONE, 2);
         b = floor_div(b + Q16_ONE, 2);
      end
      res.lightness   = scaled(l);
      res.green_red   = scaled(a);
      res.blue_yellow = scaled(b);
      return res;
   endfunction

   always @(posedge clock) begin
      lab_type want;
      if (reset) begin
         inv_x = INV_WHITE_X_RST;
         inv_y = INV_WHITE_Y_RST;
         inv_z = INV_WHITE_Z_RST;
         scale = OUT_SCALE_RST;
         offset_on = 1'b0;
         lab_queue.delete();
         error_count = 0;
      end else begin
         // register writes first; the bench must make them only while idle, the checker does not enforce it
         if (csr_write_en) begin
            case (csr_index)
               REG_INV_WHITE_X: inv_x = csr_write_data;
               REG_INV_WHITE_Y: inv_y = csr_write_data;
               REG_INV_WHITE_Z: inv_z = csr_write_data;
               REG_OUT_SCALE:   scale = csr_write_data[SCALE_W-1:0];
               REG_OFFSET_MODE: offset_on = csr_write_data[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            lab_queue.insert(lab_queue.size(),
                             predict_lab(req_x_value, req_y_value, req_z_value));
         if (rsp_valid && rsp_ready) begin
            if (lab_queue.size() == 0) begin
               $display("%0t: unexpected result beat L=%0d a=%0d b=%0d", $time,
                        rsp_lightness, rsp_green_red, rsp_blue_yellow);
               error_count++;
            end else begin
               want = lab_queue.pop_front();
               if (want.lightness !== rsp_lightness) begin
                  $display("%0t: lightness expected %0d actual %0d", $time,
                           want.lightness, rsp_lightness);
                  error_count++;
               end
               if (want.green_red !== rsp_green_red) begin
                  $display("%0t: green_red expected %0d actual %0d", $time,
                           want.green_red, rsp_green_red);
                  error_count++;
               end
               if (want.blue_yellow !== rsp_blue_yellow) begin
                  $display("%0t: blue_yellow expected %0d actual %0d", $time,
                           want.blue_yellow, rsp_blue_yellow);
                  error_count++;
               end
            end
         end
      end
      pending_count = lab_queue.size();
   end
endmodule

// ===== verif/xyz_to_cielab_converter_test.sv =====
// Top of the XYZ to CIELAB converter testbench: clock, reset, pixel stimulus,
// register settings and verdict. Depends on xyzlab_pkg, the converter and checker.
module xyz_to_cielab_converter_test;
   timeunit 1ns;
   timeprecision 1ps;
   import xyzlab_pkg::*;

   localparam int LATENCY   = 23;
   localparam int MAX_CYCLES = 400000;

   // indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_5 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_7 = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [15:0] req_x_value = '0, req_y_value = '0, req_z_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_lightness, rsp_green_red, rsp_blue_yellow;
   logic csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;
   int error_count, pending_count;
   int send_idle_pct = 0, recv_stall_pct = 0;
   bit hold_off = 1'b0;
   int cycle_count = 0;

   xyz_to_cielab_converter u_dut (.*);
   xyz_to_cielab_checker u_checker (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLES) begin
         $display("status: fail");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
   end

   // one pixel beat, held until accepted; valid drops only on idle cycles
   task automatic send_pixel(logic [15:0] xv, logic [15:0] yv, logic [15:0] zv);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_x_value <= xv;
      req_y_value <= yv;
      req_z_value <= zv;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   // drain all outstanding beats before touching registers
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   // random code biased toward the interesting corners
   function automatic logic [15:0] rand_code();
      case ($urandom_range(5))
         0: return 16'($urandom_range(300));
         1: return 16'hFFFF - 16'($urandom_range(15));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_pixels(int count);
      repeat (count) send_pixel(rand_code(), rand_code(), rand_code());
   endtask

   task automatic set_all(logic [31:0] ix, logic [31:0] iy, logic [31:0] iz,
                          logic [31:0] sc, logic [31:0] om);
      drain();
      write_reg(REG_INV_WHITE_X, ix);
      write_reg(REG_INV_WHITE_Y, iy);
      write_reg(REG_INV_WHITE_Z, iz);
      write_reg(REG_OUT_SCALE, sc);
      write_reg(REG_OFFSET_MODE, om);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: field extremes, threshold neighbourhood, default registers
      send_pixel(16'h0000, 16'h0000, 16'h0000);
      send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_pixel(16'hFFFF, 16'h0000, 16'hFFFF);
      send_pixel(16'h0000, 16'hFFFF, 16'h0000);
      send_pixel(16'd580, 16'd580, 16'd580);       // Y's t just under the threshold
      send_pixel(16'd581, 16'd581, 16'd581);       // Y's t just over
      send_pixel(16'hAAAA, 16'h5555, 16'h8001);
      send_pixel(16'h5555, 16'hAAAA, 16'h7FFE);
      // ratio saturation and maximal output scale
      set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h00FF_FFFF, 32'd1);
      send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_pixel(16'h0000, 16'hFFFF, 16'h0001);
      send_pixel(16'hFFFF, 16'h0000, 16'h0000);
      send_pixel(16'h0001, 16'h0002, 16'hFFFF);
      // zero output scale, unknown register index ignored
      set_all(32'd0, 32'd16777216, 32'hFFFF_FFFF, 32'd0, 32'd0);
      write_reg(REG_SPARE_7, 32'hFFFF_FFFF);
      write_reg(REG_SPARE_5, 32'h1234_5678);
      send_pixel(16'hFFFF, 16'h1234, 16'hFFFF);
      send_pixel(16'h0000, 16'h0000, 16'h0000);

      // random phases over several settings and idling patterns
      set_all(INV_WHITE_X_RST, INV_WHITE_Y_RST, INV_WHITE_Z_RST, 32'(OUT_SCALE_RST),
              32'd0);
      random_pixels(250);
      send_idle_pct = 54;
      random_pixels(200);
      set_all($urandom, $urandom, $urandom, 32'($urandom_range(1024)), 32'd1);
      send_idle_pct = 0; recv_stall_pct = 54;
      random_pixels(250);
      send_idle_pct = 29; recv_stall_pct = 29;
      set_all(32'h00FF_FFFF, 32'h0200_0000, 32'h0080_0000, 32'h00FF_FFFF, 32'd0);
      random_pixels(250);
      // long receiver hold-off so the pipeline fills and stalls the input
      send_idle_pct = 0; recv_stall_pct = 0;
      fork
         begin
            hold_off = 1'b1;
            repeat (120) @(negedge clock);
            hold_off = 1'b0;
         end
         random_pixels(100);
      join
      set_all($urandom, $urandom, $urandom, $urandom, $urandom);
      recv_stall_pct = 54;
      random_pixels(250);
      set_all(32'hFFFF_FFFF, 32'd1, $urandom, 32'd1, 32'd1);
      send_idle_pct = 54; recv_stall_pct = 0;
      random_pixels(250);

      drain();
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/core/xyzlab_pkg.sv
rtl/core/xyzlab_front.sv
rtl/core/xyzlab_root_cell.sv
rtl/core/xyzlab_back.sv
rtl/core/xyz_to_cielab_converter.sv
rtl/core/xyzlab_checker.sv
verif/xyz_to_cielab_checker.sv
verif/xyz_to_cielab_converter_test.sv
